FILE: rtl/core/bfbp_pkg.sv
`default_nettype none

package bfbp_pkg;

  // Sizes and starts are kept in units of 256 bytes.
  localparam int unsigned UNIT_SHIFT = 8;
  localparam int unsigned START_W    = 24;
  localparam int unsigned SIZE_W     = 25;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef logic [1:0] op_t;
  localparam op_t OP_ALLOCATE = 2'd0;
  localparam op_t OP_RELEASE  = 2'd1;
  localparam op_t OP_CLEAR    = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_REUSED    = 3'd0;
  localparam status_t ST_NEW_BLOCK = 3'd1;
  localparam status_t ST_NO_SPACE  = 3'd2;
  localparam status_t ST_RELEASED  = 3'd3;
  localparam status_t ST_IGNORED   = 3'd4;
  localparam status_t ST_NOT_FOUND = 3'd5;
  localparam status_t ST_CLEARED   = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT = 2'd1;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic               busy;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/best_fit_block_pool_top.sv
// Flow: a clear, a null release, an unknown operation or any request against an empty
//   table goes straight from idle to the decision; allocate and release with a
//   non-empty table first scan every entry (up to ENTRIES) before the decision.
// Throughput: one item at a time; the table scan reads one entry per cycle from the single
//   entry memory, and the decision also waits out any result stall.
// Reset: synchronous rst empties the table, zeroes total and peak, sets pool_base to 0 and
//   the limit to 4 GiB. The entry memory needs no clearing pass: only entries below the
//   fill count are ever used, and each of those was written by an append.
`default_nettype none

module best_fit_block_pool_top #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire                               clk,
  input  wire                               rst,
  // configuration write channel
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [bfbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [32:0]                       cfg_data,
  // request channel
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [1:0]                        operation,
  input  wire  [31:0]                       request_bytes,
  input  wire  [31:0]                       block_address,
  // result channel
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [31:0]                       granted_address,
  output logic [2:0]                        status,
  output logic [32:0]                       held_bytes,
  output logic [32:0]                       peak_bytes
);
  import bfbp_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  // Configuration registers; the low byte of the base is dropped on write.
  logic [START_W-1:0] base_units;
  logic [32:0]        pool_limit;

  // Pool bookkeeping
  logic [CW-1:0]      count;
  logic [SIZE_W-1:0]  total_units;
  logic [SIZE_W-1:0]  peak_units;

  // Control
  logic [1:0]         state;
  logic [CW-1:0]      issue_idx;
  logic               chk_valid;
  logic [IW-1:0]      chk_idx;

  // Latched request
  op_t                op;
  logic [SIZE_W-1:0]  units;
  logic [START_W-1:0] rel_key;
  logic               rel_aligned;
  logic               rel_null;

  // Scan results
  logic               found;
  logic [IW-1:0]      best_idx;
  entry_t             best_entry;

  // Entry memory
  entry_t             mem [ENTRIES];
  entry_t             rd_entry;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  entry_t             mem_wdata;

  // Decide datapath
  logic [25:0]        new_start;
  logic [26:0]        new_end;
  logic [25:0]        new_total;
  logic               over_limit;
  logic               append_ok;
  logic               decide_fire;
  logic               in_xfer;
  logic               scan_last;
  logic               cand_fit;
  logic               cand_match;
  logic [32:0]        round_sum;

  // Result fields of the item being decided
  logic [31:0]        res_addr;
  status_t            res_status;
  logic [32:0]        res_held;
  logic [32:0]        res_peak;

  assign cfg_ready   = 1'b1;
  assign in_ready    = (state == S_IDLE);
  assign in_xfer     = in_valid && in_ready;
  // Fire the decision only when the result register can take it.
  assign decide_fire = (state == S_DECIDE) && (!out_valid || out_ready);
  assign round_sum   = {1'b0, request_bytes} + 33'd255;

  assign scan_last  = chk_valid && ((CW'(chk_idx) + CW'(1)) == count);
  // Best fit: free, big enough, strictly smaller than the best so far (earliest wins ties).
  assign cand_fit   = chk_valid && !rd_entry.busy && (rd_entry.size >= units) &&
                      (!found || (rd_entry.size < best_entry.size));
  // Release: first entry whose start matches, aligned addresses only.
  assign cand_match = chk_valid && !found && rel_aligned && (rd_entry.start == rel_key);

  always_comb begin
    new_start  = {2'b00, base_units} + {1'b0, total_units};
    new_end    = {1'b0, new_start} + {2'b00, units};
    new_total  = {1'b0, total_units} + {1'b0, units};
    over_limit = {new_total, 8'h00} > {1'b0, pool_limit};
    append_ok  = (count < CW'(ENTRIES)) && !over_limit && (new_start[25:24] == 2'b00) &&
                 (new_end <= 27'(1 << START_W));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_idx;
    mem_wdata = best_entry;
    if (decide_fire) begin
      case (op)
        OP_ALLOCATE: begin
          if (found) begin
            mem_we         = 1'b1;
            mem_wdata.busy = 1'b1;
          end else if (append_ok) begin
            mem_we          = 1'b1;
            mem_waddr       = count[IW-1:0];
            mem_wdata.start = new_start[START_W-1:0];
            mem_wdata.size  = units;
            mem_wdata.busy  = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (found) begin
            mem_we         = 1'b1;
            mem_wdata.busy = 1'b0;
          end
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // Build the result of the current decision.
  always_comb begin
    res_addr   = '0;
    res_status = ST_IGNORED;
    res_held   = {total_units, 8'h00};
    res_peak   = {peak_units, 8'h00};
    case (op)
      OP_ALLOCATE: begin
        if (found) begin
          res_addr   = {best_entry.start, 8'h00};
          res_status = ST_REUSED;
        end else if (append_ok) begin
          res_addr   = {new_start[START_W-1:0], 8'h00};
          res_status = ST_NEW_BLOCK;
          res_held   = {new_total[SIZE_W-1:0], 8'h00};
          if (new_total[SIZE_W-1:0] > peak_units) begin
            res_peak = {new_total[SIZE_W-1:0], 8'h00};
          end
        end else begin
          res_status = ST_NO_SPACE;
        end
      end
      OP_RELEASE: begin
        if (rel_null) begin
          res_status = ST_IGNORED;
        end else if (found) begin
          res_status = ST_RELEASED;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        res_status = ST_CLEARED;
        res_held   = '0;
      end
      default: begin
        res_status = ST_IGNORED;
      end
    endcase
  end

  // Single write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_entry <= mem[issue_idx[IW-1:0]];
  end

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_units <= '0;
      pool_limit <= 33'h1_0000_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POOL_BASE:  base_units <= cfg_data[31:UNIT_SHIFT];
        CFG_POOL_LIMIT: pool_limit <= cfg_data;
        default:        base_units <= base_units;
      endcase
    end
  end

  // Control state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      issue_idx   <= '0;
      chk_valid   <= 1'b0;
      count       <= '0;
      total_units <= '0;
      peak_units  <= '0;
      out_valid   <= 1'b0;
      found       <= 1'b0;
    end else begin
      // Drop the result once it is taken, unless a new one lands in the same cycle.
      if (out_valid && out_ready && !decide_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            issue_idx <= '0;
            chk_valid <= 1'b0;
            found     <= 1'b0;
            // Scan only for allocate and non-null release with a non-empty table.
            if ((count != '0) && ((operation == OP_ALLOCATE) ||
                ((operation == OP_RELEASE) && (block_address != 32'd0)))) begin
              state <= S_SCAN;
            end else begin
              state <= S_DECIDE;
            end
          end
        end
        S_SCAN: begin
          chk_valid <= (issue_idx < count) && !scan_last;
          if (issue_idx < count) begin
            issue_idx <= issue_idx + CW'(1);
          end
          if ((op == OP_ALLOCATE) ? cand_fit : cand_match) begin
            found <= 1'b1;
          end
          if (scan_last) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (decide_fire) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            case (op)
              OP_ALLOCATE: begin
                if (!found && append_ok) begin
                  count       <= count + CW'(1);
                  total_units <= new_total[SIZE_W-1:0];
                  if (new_total[SIZE_W-1:0] > peak_units) begin
                    peak_units <= new_total[SIZE_W-1:0];
                  end
                end
              end
              OP_CLEAR: begin
                count       <= '0;
                total_units <= '0;
              end
              default: begin
                count <= count;
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: latched request, scan tracking and result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op          <= operation;
      units       <= round_sum[32:UNIT_SHIFT];
      rel_key     <= block_address[31:UNIT_SHIFT];
      rel_aligned <= (block_address[UNIT_SHIFT-1:0] == '0);
      rel_null    <= (block_address == 32'd0);
    end
    if (state == S_SCAN) begin
      chk_idx <= issue_idx[IW-1:0];
      if ((op == OP_ALLOCATE) ? cand_fit : cand_match) begin
        best_idx   <= chk_idx;
        best_entry <= rd_entry;
      end
    end
    if (decide_fire) begin
      granted_address <= res_addr;
      status          <= res_status;
      held_bytes      <= res_held;
      peak_bytes      <= res_peak;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("entry count beyond table depth");

  a_total_le_peak: assert property (@(posedge clk) disable iff (rst)
    total_units <= peak_units)
    else $error("total exceeds peak");

  a_chk_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> (state == S_SCAN))
    else $error("scan data outside scan");

  a_write_on_decide: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> decide_fire)
    else $error("entry write outside decision");

  a_decide_result: assert property (@(posedge clk) disable iff (rst)
    decide_fire |=> (out_valid && (state == S_IDLE)))
    else $error("decision did not produce a result");

endmodule

`default_nettype wire

FILE: tb/sv/best_fit_block_pool_top_tb.sv
`timescale 1ns / 100ps

module best_fit_block_pool_top_tb;
  import bfbp_pkg::*;

  localparam int unsigned ENTRIES      = 64;
  localparam int unsigned DRAIN_CYCLES = ENTRIES + 16;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 130;
  // The package names three operations; the fourth code must be ignored by the block.
  localparam op_t OP_UNKNOWN = 2'd3;

  // One response as it leaves the result channel.
  typedef struct packed {
    logic [31:0] addr;
    status_t     status;
    logic [32:0] total;
    logic [32:0] peak;
  } pool_result_t;

  // One line of the directed script: either a register write or a request. Requests whose
  // outcome is obvious carry it typed in; the others take the shadow pool's answer.
  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [32:0]          reg_value;
    op_t                  op;
    logic [31:0]          bytes;
    logic [31:0]          addr;
    bit                   typed;
    pool_result_t         want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [32:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  operation;
  logic [31:0] request_bytes;
  logic [31:0] block_address;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] granted_address;
  logic [2:0]  status;
  logic [32:0] held_bytes;
  logic [32:0] peak_bytes;

  best_fit_block_pool_top #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .request_bytes  (request_bytes),
    .block_address  (block_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .granted_address(granted_address),
    .status         (status),
    .held_bytes     (held_bytes),
    .peak_bytes     (peak_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Shadow pool: a private copy of the block table, the held and peak totals and the two
  // registers. Sizes and starts are in 256-byte units, as in the block.
  // ---------------------------------------------------------------------------------------
  logic [START_W-1:0] slot_start [ENTRIES];
  logic [SIZE_W-1:0]  slot_size  [ENTRIES];
  bit                 slot_busy  [ENTRIES];
  int unsigned        pool_fill       = 0;
  logic [SIZE_W-1:0]  held_units      = '0;
  logic [SIZE_W-1:0]  peak_held_units = '0;
  logic [31:0]        base_reg        = '0;
  logic [32:0]        limit_reg       = 33'h1_0000_0000;

  // Responses owed by the block, oldest first.
  pool_result_t awaited_responses [$];
  int unsigned  mismatches = 0;

  // Idle rates in percent, changed per phase.
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  script_row_t script [$];

  // Apply one request to the shadow pool and return the response it must produce.
  function automatic pool_result_t predict_pool_response(op_t op, logic [31:0] bytes,
                                                         logic [31:0] addr);
    pool_result_t       r;
    logic [32:0]        rounded;
    logic [SIZE_W-1:0]  units;
    logic [25:0]        bump_units;
    logic [25:0]        grown_units;
    logic [26:0]        end_units;
    int                 best;
    int                 i;
    bit                 hit;
    r.addr   = '0;
    r.status = ST_IGNORED;
    case (op)
      OP_ALLOCATE: begin
        rounded = {1'b0, bytes} + 33'd255;
        units   = rounded[32:8];
        best    = -1;
        // Smallest free block that fits; strict compare keeps the lowest entry on a tie.
        for (i = 0; i < int'(pool_fill); i++) begin
          if (!slot_busy[i] && slot_size[i] >= units &&
              (best < 0 || slot_size[i] < slot_size[best]))
            best = i;
        end
        if (best >= 0) begin
          slot_busy[best] = 1'b1;
          r.addr   = {slot_start[best], 8'h00};
          r.status = ST_REUSED;
        end else begin
          bump_units  = 26'(base_reg[31:8]) + 26'(held_units);
          grown_units = 26'(held_units) + 26'(units);
          end_units   = 27'(bump_units) + 27'(units);
          if (pool_fill >= ENTRIES || {grown_units, 8'h00} > {1'b0, limit_reg} ||
              27'(bump_units) >= (27'd1 << START_W) || end_units > (27'd1 << START_W)) begin
            r.status = ST_NO_SPACE;
          end else begin
            slot_start[pool_fill] = bump_units[START_W-1:0];
            slot_size[pool_fill]  = units;
            slot_busy[pool_fill]  = 1'b1;
            pool_fill++;
            held_units = grown_units[SIZE_W-1:0];
            if (held_units > peak_held_units)
              peak_held_units = held_units;
            r.addr   = {bump_units[START_W-1:0], 8'h00};
            r.status = ST_NEW_BLOCK;
          end
        end
      end
      OP_RELEASE: begin
        if (addr != '0) begin
          hit = 1'b0;
          for (i = 0; i < int'(pool_fill) && !hit; i++) begin
            if ({slot_start[i], 8'h00} == addr) begin
              slot_busy[i] = 1'b0;
              hit = 1'b1;
            end
          end
          r.status = hit ? ST_RELEASED : ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < ENTRIES; i++)
          slot_busy[i] = 1'b0;
        pool_fill  = 0;
        held_units = '0;
        r.status   = ST_CLEARED;
      end
      default: r.status = ST_IGNORED;
    endcase
    r.total = {held_units, 8'h00};
    r.peak  = {peak_held_units, 8'h00};
    return r;
  endfunction

  function automatic void add_request(op_t op, logic [31:0] bytes, logic [31:0] addr);
    script_row_t row;
    row = '{default: '0};
    row.op    = op;
    row.bytes = bytes;
    row.addr  = addr;
    script.insert(script.size(), row);
  endfunction

  function automatic void add_known(op_t op, logic [31:0] bytes, logic [31:0] addr,
                                    logic [31:0] granted, status_t st,
                                    logic [32:0] total, logic [32:0] peak);
    script_row_t row;
    row = '{default: '0};
    row.op    = op;
    row.bytes = bytes;
    row.addr  = addr;
    row.typed = 1'b1;
    row.want  = '{addr: granted, status: st, total: total, peak: peak};
    script.insert(script.size(), row);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [32:0] value);
    script_row_t row;
    row = '{default: '0};
    row.is_write  = 1'b1;
    row.reg_index = idx;
    row.reg_value = value;
    script.insert(script.size(), row);
  endfunction

  function automatic void check_field(string name, logic [32:0] want, logic [32:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Hold until every owed response has been taken off the result channel.
  task automatic hold_until_drained();
    while (awaited_responses.size() != 0)
      @(posedge clk);
  endtask

  // Present one request, wait for its transfer, then log what the block owes for it.
  task automatic send_request(op_t op, logic [31:0] bytes, logic [31:0] addr,
                              bit typed, pool_result_t typed_want);
    pool_result_t predicted;
    cfg_valid <= 1'b0;
    // Random gap before the item; valid drops only when a gap is actually taken.
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    request_bytes <= bytes;
    block_address <= addr;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    predicted = predict_pool_response(op, bytes, addr);
    awaited_responses.insert(awaited_responses.size(), typed ? typed_want : predicted);
  endtask

  // Write a register with the pool quiet: no request pending and no response owed.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [32:0] value);
    in_valid <= 1'b0;
    hold_until_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    case (idx)
      CFG_POOL_BASE:  base_reg  = {value[31:8], 8'h00};
      CFG_POOL_LIMIT: limit_reg = value;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side: randomly stall ready, and compare every transfer against the oldest
  // owed response, field by field.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : response_check
    pool_result_t want;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (awaited_responses.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected response: expected none, got addr %0h status %0d",
                 $time, granted_address, status);
      end else begin
        want = awaited_responses.pop_front();
        check_field("granted_address", 33'(want.addr), 33'(granted_address));
        check_field("status", 33'(want.status), 33'(status));
        check_field("held_bytes", want.total, held_bytes);
        check_field("peak_bytes", want.peak, peak_bytes);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int unsigned  r;
    int unsigned  p;
    int unsigned  k;
    int unsigned  roll;
    int unsigned  pick;
    int unsigned  clear_pm;
    int unsigned  alloc_cut;
    logic [32:0]  base_val;
    logic [32:0]  limit_val;
    op_t          op;
    logic [31:0]  bytes;
    logic [31:0]  addr;
    pool_result_t no_typed;

    no_typed      = '0;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    operation     = OP_ALLOCATE;
    request_bytes = '0;
    block_address = '0;

    // Directed script. Defaults after reset: base 0, limit 4 GiB.
    add_known(OP_RELEASE, 32'hFFFF_FFFF, 32'h0, 32'h0, ST_IGNORED, 33'h0, 33'h0);
    add_known(OP_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, ST_IGNORED, 33'h0, 33'h0);
    // Zero-byte block at base 0: granted at address 0, and 0 can never be released.
    add_known(OP_ALLOCATE, 32'h0, 32'h0, 32'h0, ST_NEW_BLOCK, 33'h0, 33'h0);
    add_known(OP_ALLOCATE, 32'h1, 32'h0, 32'h0, ST_NEW_BLOCK, 33'h100, 33'h100);
    // Largest request rounds to 2^24 units and overruns the limit.
    add_known(OP_ALLOCATE, 32'hFFFF_FFFF, 32'h0, 32'h0, ST_NO_SPACE, 33'h100, 33'h100);
    add_known(OP_ALLOCATE, 32'h100, 32'h0, 32'h100, ST_NEW_BLOCK, 33'h200, 33'h200);
    add_known(OP_RELEASE, 32'h0, 32'h100, 32'h0, ST_RELEASED, 33'h200, 33'h200);
    // Unaligned address matches nothing.
    add_known(OP_RELEASE, 32'h0, 32'h101, 32'h0, ST_NOT_FOUND, 33'h200, 33'h200);
    add_request(OP_ALLOCATE, 32'd100, 32'h0);
    add_request(OP_RELEASE, 32'h0, 32'h100);
    // Release of a block that is already free.
    add_request(OP_RELEASE, 32'h0, 32'h100);
    add_request(OP_ALLOCATE, 32'h0, 32'h0);
    add_request(OP_ALLOCATE, 32'h100, 32'h0);
    // Two free blocks of equal size: the lower entry must win.
    add_request(OP_RELEASE, 32'h0, 32'h200);
    add_request(OP_RELEASE, 32'h0, 32'h100);
    add_request(OP_ALLOCATE, 32'h1, 32'h0);
    add_request(OP_ALLOCATE, 32'h1, 32'h0);
    add_known(OP_CLEAR, 32'h0, 32'h0, 32'h0, ST_CLEARED, 33'h0, 33'h300);
    // Top of the address space; low base bits and bit 32 of the data must be dropped.
    add_write(CFG_POOL_BASE, 33'h1_FFFF_FFFF);
    add_write(CFG_POOL_LIMIT, 33'h1_0000_0000);
    add_known(OP_ALLOCATE, 32'h0, 32'h0, 32'hFFFF_FF00, ST_NEW_BLOCK, 33'h0, 33'h300);
    add_known(OP_ALLOCATE, 32'h1, 32'h0, 32'hFFFF_FF00, ST_NEW_BLOCK, 33'h100, 33'h300);
    add_known(OP_ALLOCATE, 32'h1, 32'h0, 32'h0, ST_NO_SPACE, 33'h100, 33'h300);
    add_known(OP_RELEASE, 32'h0, 32'hFFFF_FF00, 32'h0, ST_RELEASED, 33'h100, 33'h300);
    add_known(OP_CLEAR, 32'h0, 32'h0, 32'h0, ST_CLEARED, 33'h0, 33'h300);
    // Zero limit: only zero-byte blocks fit.
    add_write(CFG_POOL_BASE, 33'h0_0001_2345);
    add_write(CFG_POOL_LIMIT, 33'h0);
    add_known(OP_ALLOCATE, 32'h0, 32'h0, 32'h0001_2300, ST_NEW_BLOCK, 33'h0, 33'h300);
    add_known(OP_ALLOCATE, 32'h1, 32'h0, 32'h0, ST_NO_SPACE, 33'h0, 33'h300);
    add_known(OP_CLEAR, 32'h0, 32'h0, 32'h0, ST_CLEARED, 33'h0, 33'h300);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < script.size(); r++) begin
      if (script[r].is_write)
        write_register(script[r].reg_index, script[r].reg_value);
      else
        send_request(script[r].op, script[r].bytes, script[r].addr,
                     script[r].typed, script[r].want);
    end

    // Random phases. Each one rotates the idle pattern and picks fresh register values.
    for (p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 49; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 49; end
        default: begin send_gap_pct = 9; recv_stall_pct = 9; end
      endcase

      if (p == 0) begin
        // Roomy pool and no clears: drive the table until it is full.
        base_val  = 33'h0;
        limit_val = 33'h1_0000_0000;
        clear_pm  = 0;
        alloc_cut = 850;
      end else begin
        case ($urandom_range(3))
          0: base_val = 33'h0;
          1: base_val = {1'($urandom_range(1)), $urandom()};
          2: base_val = {1'b0, 16'hFFFF, 16'($urandom())};
          default: base_val = 33'($urandom_range(0, 32'h0010_0000));
        endcase
        case ($urandom_range(3))
          0: limit_val = 33'h1_0000_0000;
          1: limit_val = 33'h0;
          2: limit_val = 33'($urandom_range(0, 32'h0010_0000));
          default: limit_val = {1'b0, $urandom()};
        endcase
        clear_pm  = 15;
        alloc_cut = 600;
      end
      write_register(CFG_POOL_BASE, base_val);
      write_register(CFG_POOL_LIMIT, limit_val);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        // Let the block run completely dry once before carrying on.
        if (p == 2 && k == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          hold_until_drained();
        end

        roll = $urandom_range(999);
        if (roll < clear_pm)
          op = OP_CLEAR;
        else if (roll < clear_pm + 20)
          op = OP_UNKNOWN;
        else if (roll < alloc_cut)
          op = OP_ALLOCATE;
        else
          op = OP_RELEASE;

        // Mostly small sizes so the table fills and blocks get reused.
        case ($urandom_range(19))
          0:               bytes = $urandom();
          1, 2:            bytes = 32'h0;
          3, 4, 5, 6, 7, 8, 9, 10: bytes = $urandom_range(1, 4096);
          11, 12, 13, 14, 15, 16:  bytes = $urandom_range(0, 32) << 8;
          default:         bytes = $urandom_range(4097, 32'h0010_0000);
        endcase

        // Releases mostly aim at addresses that are in the table.
        addr = $urandom();
        if (op == OP_RELEASE) begin
          pick = $urandom_range(9);
          if (pool_fill != 0 && pick < 7)
            addr = {slot_start[$urandom_range(pool_fill - 1)], 8'h00};
          else if (pick == 7)
            addr = 32'h0;
          else if (pool_fill != 0 && pick == 9)
            addr = {slot_start[$urandom_range(pool_fill - 1)], 8'($urandom_range(1, 255))};
        end

        send_request(op, bytes, addr, 1'b0, no_typed);
      end
    end

    // Drain, then give the block time to show any stray response.
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
